>>> hw/rtl/skt_pkg.sv
// skt_pkg: types, codes and defaults shared by the sorted key table files.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package skt_pkg;

    // Default sizes, handed to the top level parameters
    localparam int CAPACITY_DEF    = 64;
    localparam int HANDLE_BITS_DEF = 32;

    // Fixed field widths of the item ports
    localparam int KEY_W    = 64;
    localparam int HANDLE_W = 32;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 7;

    // Command codes
    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE_KEY = 3'd1,
        OP_REMOVE_POS = 3'd2,
        OP_FIND       = 3'd3,
        OP_READ_POS   = 3'd4,
        OP_CLEAR      = 3'd5
    } op_e;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_ABSENT = 2'd2,
        STS_RANGE  = 2'd3
    } status_e;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DISPATCH,
        S_POS_RD,
        S_POS_CAP,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [2:0]          operation;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [POS_W-1:0]    position;
    } cmd_item_t;

    typedef struct packed {
        logic                found;
        logic [CNT_W-1:0]    where_at;
        logic [KEY_W-1:0]    entry_key;
        logic [HANDLE_W-1:0] entry_handle;
        logic [CNT_W-1:0]    entry_count;
        logic [1:0]          status;
    } rsp_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/sorted_key_table.sv
// sorted_key_table: top level of a key-ordered table with binary search lookup.
// Instantiates skt_ctrl and skt_store; types and defaults come from skt_pkg.
//
//   port group   direction  handshake          payload
//   cmd          in         cmd_valid/stall    skt_pkg::cmd_item_t
//   rsp          out        rsp_valid/stall    skt_pkg::rsp_item_t
//
// One item at a time: the command side stalls until the result is handed to the output register.
// A key command runs search probes, each a memory read and then a compare, at most
// ceil(log2(count+1)) probes, plus a range check, dispatch, result load and the idle state.
// A new key adds a write; insert and remove add a read and a write per entry moved, using the
// separate read and write ports. In range, position commands read and capture the entry, plus
// the move; out of range, and for clear and unused codes, the result is loaded straight away.
// Reset clears the entry count, the sequencer state and the result valid flag; the memory needs no clearing pass.
// A result waits in the output register while the next item is taken in; the result after
// it holds in the sequencer until that register frees.
`default_nettype none

module sorted_key_table #(
    parameter int CAPACITY    = skt_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire skt_pkg::cmd_item_t cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output skt_pkg::rsp_item_t      rsp
);

    localparam int HW = (HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS : skt_pkg::HANDLE_W;
    localparam int AW = $clog2(CAPACITY);

    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [skt_pkg::KEY_W-1:0] wr_key;
    logic [HW-1:0]             wr_handle;
    logic [AW-1:0]             rd_addr;
    logic [skt_pkg::KEY_W-1:0] rd_key;
    logic [HW-1:0]             rd_handle;

    skt_ctrl #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_handle (wr_handle),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_handle (rd_handle)
    );

    skt_store #(
        .CAPACITY    (CAPACITY),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_key    (wr_key),
        .wr_handle (wr_handle),
        .rd_addr   (rd_addr),
        .rd_key    (rd_key),
        .rd_handle (rd_handle)
    );

endmodule

`default_nettype wire

>>> hw/rtl/skt_store.sv
// skt_store: entry memory of the sorted key table, keys and handles side by side.
// One write port, one read port with registered read data. Uses skt_pkg.
`default_nettype none

module skt_store #(
    parameter int CAPACITY    = skt_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0]   wr_addr,
    input  wire logic [skt_pkg::KEY_W-1:0]     wr_key,
    input  wire logic [((HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS
                        : skt_pkg::HANDLE_W)-1:0] wr_handle,
    input  wire logic [$clog2(CAPACITY)-1:0]   rd_addr,
    output logic      [skt_pkg::KEY_W-1:0]     rd_key,
    output logic      [((HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS
                        : skt_pkg::HANDLE_W)-1:0] rd_handle
);

    localparam int HW = (HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS : skt_pkg::HANDLE_W;

    logic [skt_pkg::KEY_W-1:0] key_mem    [CAPACITY];
    logic [HW-1:0]             handle_mem [CAPACITY];
    logic [skt_pkg::KEY_W-1:0] rd_key_reg;
    logic [HW-1:0]             rd_handle_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]    <= wr_key;
            handle_mem[wr_addr] <= wr_handle;
        end
    end

    // Read one entry, data out next cycle
    always_ff @(posedge clk)
    begin
        rd_key_reg    <= key_mem[rd_addr];
        rd_handle_reg <= handle_mem[rd_addr];
    end

    assign rd_key    = rd_key_reg;
    assign rd_handle = rd_handle_reg;

endmodule

`default_nettype wire

>>> hw/rtl/skt_ctrl.sv
// skt_ctrl: sequencer and shared key comparator of the sorted key table.
// Runs the binary search, the shift loops and the result register. Uses skt_pkg.
`default_nettype none

module skt_ctrl #(
    parameter int CAPACITY    = skt_pkg::CAPACITY_DEF,
    parameter int HANDLE_BITS = skt_pkg::HANDLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire skt_pkg::cmd_item_t            cmd,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output skt_pkg::rsp_item_t                 rsp,
    output logic                               wr_en,
    output logic      [$clog2(CAPACITY)-1:0]   wr_addr,
    output logic      [skt_pkg::KEY_W-1:0]     wr_key,
    output logic      [((HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS
                        : skt_pkg::HANDLE_W)-1:0] wr_handle,
    output logic      [$clog2(CAPACITY)-1:0]   rd_addr,
    input  wire logic [skt_pkg::KEY_W-1:0]     rd_key,
    input  wire logic [((HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS
                        : skt_pkg::HANDLE_W)-1:0] rd_handle
);

    localparam int HW = (HANDLE_BITS < skt_pkg::HANDLE_W) ? HANDLE_BITS : skt_pkg::HANDLE_W;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = skt_pkg::KEY_W;
    localparam logic [CW:0] CAP_W1 = (CW + 1)'(CAPACITY);

    // Control registers
    skt_pkg::state_e state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;

    // Working and payload registers
    logic [2:0]               op_reg, op_next;
    logic [KW-1:0]            key_reg, key_next;
    logic [HW-1:0]            handle_reg, handle_next;
    logic [skt_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]            lo_reg, lo_next;
    logic [CW-1:0]            hi_reg, hi_next;
    logic [CW-1:0]            mid_reg, mid_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     hit_reg, hit_next;
    logic [KW-1:0]            sv_key_reg, sv_key_next;
    logic [HW-1:0]            sv_handle_reg, sv_handle_next;
    logic                     found_reg, found_next;
    logic [skt_pkg::CNT_W-1:0] where_reg, where_next;
    logic [KW-1:0]            ek_reg, ek_next;
    logic [HW-1:0]            eh_reg, eh_next;
    skt_pkg::status_e         status_reg, status_next;
    skt_pkg::rsp_item_t       out_reg, out_next;

    // Comparator and index arithmetic
    logic          key_lt;
    logic          key_eq;
    logic [CW-1:0] mid;
    logic [CW:0]   lo_w1;
    logic [CW:0]   idx_w1;
    logic [CW:0]   count_w1;
    logic          pos_in_range;

    assign key_lt   = (rd_key < key_reg);
    assign key_eq   = (rd_key == key_reg);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_w1    = {1'b0, lo_reg};
    assign idx_w1   = {1'b0, idx_reg};
    assign count_w1 = {1'b0, count_reg};
    assign pos_in_range = (32'(cmd.position) < 32'(count_reg));

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working values and the result
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        handle_reg    <= handle_next;
        pos_reg       <= pos_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        sv_key_reg    <= sv_key_next;
        sv_handle_reg <= sv_handle_next;
        found_reg     <= found_next;
        where_reg     <= where_next;
        ek_reg        <= ek_next;
        eh_reg        <= eh_next;
        status_reg    <= status_next;
        out_reg       <= out_next;
    end

    // Sequencer: next state, memory access and result fields
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        handle_next    = handle_reg;
        pos_next       = pos_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        sv_key_next    = sv_key_reg;
        sv_handle_next = sv_handle_reg;
        found_next     = found_reg;
        where_next     = where_reg;
        ek_next        = ek_reg;
        eh_next        = eh_reg;
        status_next    = status_reg;
        out_next       = out_reg;

        wr_en     = 1'b0;
        wr_addr   = lo_reg[AW-1:0];
        wr_key    = key_reg;
        wr_handle = handle_reg;
        rd_addr   = mid[AW-1:0];

        // Drop the result once taken
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next     = cmd.operation;
                    key_next    = cmd.key;
                    handle_next = HW'(cmd.handle);
                    pos_next    = cmd.position;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    hit_next    = 1'b0;
                    found_next  = 1'b0;
                    where_next  = '0;
                    ek_next     = '0;
                    eh_next     = '0;
                    status_next = skt_pkg::STS_OK;
                    state_next  = skt_pkg::S_DONE;
                    unique case (cmd.operation)
                        skt_pkg::OP_INSERT,
                        skt_pkg::OP_REMOVE_KEY,
                        skt_pkg::OP_FIND:
                        begin
                            state_next = skt_pkg::S_SRCH_RD;
                        end
                        skt_pkg::OP_REMOVE_POS,
                        skt_pkg::OP_READ_POS:
                        begin
                            where_next = skt_pkg::CNT_W'(cmd.position);
                            if (pos_in_range)
                            begin
                                state_next = skt_pkg::S_POS_RD;
                            end
                            else
                            begin
                                status_next = skt_pkg::STS_RANGE;
                            end
                        end
                        skt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // Unused codes change nothing
                        end
                    endcase
                end
            end

            // Probe the middle of the open range
            skt_pkg::S_SRCH_RD:
            begin
                rd_addr = mid[AW-1:0];
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = skt_pkg::S_SRCH_CMP;
                end
                else
                begin
                    state_next = skt_pkg::S_DISPATCH;
                end
            end

            // Narrow the range; keep the latest upper-bound entry
            skt_pkg::S_SRCH_CMP:
            begin
                if (key_lt)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next        = mid_reg;
                    hit_next       = key_eq;
                    sv_key_next    = rd_key;
                    sv_handle_next = rd_handle;
                end
                state_next = skt_pkg::S_SRCH_RD;
            end

            // Act on the search outcome
            skt_pkg::S_DISPATCH:
            begin
                where_next = skt_pkg::CNT_W'(lo_reg);
                state_next = skt_pkg::S_DONE;
                if (op_reg == skt_pkg::OP_INSERT)
                begin
                    if (hit_reg)
                    begin
                        wr_en      = 1'b1;
                        found_next = 1'b1;
                        ek_next    = key_reg;
                        eh_next    = handle_reg;
                    end
                    else if (count_w1 >= CAP_W1)
                    begin
                        status_next = skt_pkg::STS_FULL;
                    end
                    else
                    begin
                        idx_next = count_reg;
                        if (count_reg > lo_reg)
                        begin
                            state_next = skt_pkg::S_UP_RD;
                        end
                        else
                        begin
                            state_next = skt_pkg::S_INS_WR;
                        end
                    end
                end
                else if (hit_reg)
                begin
                    found_next = 1'b1;
                    ek_next    = sv_key_reg;
                    eh_next    = sv_handle_reg;
                    if (op_reg == skt_pkg::OP_REMOVE_KEY)
                    begin
                        idx_next = lo_reg;
                        if ((lo_w1 + (CW + 1)'(1)) < count_w1)
                        begin
                            state_next = skt_pkg::S_DN_RD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                end
                else
                begin
                    status_next = skt_pkg::STS_ABSENT;
                end
            end

            // Fetch the entry at the given position
            skt_pkg::S_POS_RD:
            begin
                rd_addr    = AW'(pos_reg);
                state_next = skt_pkg::S_POS_CAP;
            end

            skt_pkg::S_POS_CAP:
            begin
                found_next = 1'b1;
                ek_next    = rd_key;
                eh_next    = rd_handle;
                idx_next   = CW'(pos_reg);
                state_next = skt_pkg::S_DONE;
                if (op_reg == skt_pkg::OP_REMOVE_POS)
                begin
                    if ((32'(pos_reg) + 32'd1) < 32'(count_reg))
                    begin
                        state_next = skt_pkg::S_DN_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end

            // Move entries up by one, top first
            skt_pkg::S_UP_RD:
            begin
                rd_addr    = AW'(idx_reg - CW'(1));
                state_next = skt_pkg::S_UP_WR;
            end

            skt_pkg::S_UP_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = idx_reg[AW-1:0];
                wr_key    = rd_key;
                wr_handle = rd_handle;
                idx_next  = idx_reg - CW'(1);
                if ((idx_reg - CW'(1)) > lo_reg)
                begin
                    state_next = skt_pkg::S_UP_RD;
                end
                else
                begin
                    state_next = skt_pkg::S_INS_WR;
                end
            end

            // Place the new entry at the insertion point
            skt_pkg::S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[AW-1:0];
                count_next = count_reg + CW'(1);
                ek_next    = key_reg;
                eh_next    = handle_reg;
                state_next = skt_pkg::S_DONE;
            end

            // Move entries down by one, bottom first
            skt_pkg::S_DN_RD:
            begin
                rd_addr    = AW'(idx_w1 + (CW + 1)'(1));
                state_next = skt_pkg::S_DN_WR;
            end

            skt_pkg::S_DN_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = idx_reg[AW-1:0];
                wr_key    = rd_key;
                wr_handle = rd_handle;
                idx_next  = idx_reg + CW'(1);
                if ((idx_w1 + (CW + 1)'(2)) < count_w1)
                begin
                    state_next = skt_pkg::S_DN_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = skt_pkg::S_DONE;
                end
            end

            // Hand the result to the output register when it is free
            skt_pkg::S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.found        = found_reg;
                    out_next.where_at     = where_reg;
                    out_next.entry_key    = ek_reg;
                    out_next.entry_handle = skt_pkg::HANDLE_W'(eh_reg);
                    out_next.entry_count  = skt_pkg::CNT_W'(count_reg);
                    out_next.status       = status_reg;
                    out_valid_next        = 1'b1;
                    state_next            = skt_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    assign cmd_stall = (state_reg != skt_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/skt_checker.sv
// skt_checker: port-level assertions for sorted_key_table, attached by bind.
// Sees only the top level ports; uses skt_pkg for codes and item types.
`default_nettype none

module skt_checker #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_stall,
    input wire skt_pkg::cmd_item_t cmd,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire skt_pkg::rsp_item_t rsp
);

    // Count never goes past capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.entry_count) <= CAPACITY))
        else $error("entry count above capacity");

    // A hit always reports ok
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> (rsp.status == skt_pkg::STS_OK))
        else $error("found entry with non-ok status");

    // Full is only reported at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == skt_pkg::STS_FULL)
        |-> (32'(rsp.entry_count) == (CAPACITY % 128)))
        else $error("full status below capacity");

    // Busy after taking an item
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("ready right after accepting an item");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind sorted_key_table skt_checker #(
    .CAPACITY (CAPACITY)
) u_skt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
